FILE: design/szsr_pkg.sv
// ----------------------------------------------------------------------------
// szsr_pkg
// Shared types, constants and group arithmetic for the zero-sum reach tracker.
// ----------------------------------------------------------------------------
package szsr_pkg;

  localparam int MAX_TERMS   = 5;
  localparam int GROUP_ORDER = 125;
  localparam int AXIS        = 5;

  // Request kinds carried on the input tuser bit
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  typedef logic [GROUP_ORDER-1:0] gset_t;

  // One group element as three coordinates, each 0..4
  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
  } coord_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic clear;
    logic out_load;
    logic out_ok;
  } szsr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_add;
    logic count_zero;
    logic count_one;
    logic step_fail;
  } szsr_stat_t;

  // Split a 7-bit code into coordinates; codes above 124 wrap per coordinate
  function automatic coord_t decode(input logic [6:0] v);
    coord_t r;
    r = '0;
    for (int i = 0; i < 128; i++) begin
      if (v == 7'(i)) begin
        r.x = 3'((i / 25) % 5);
        r.y = 3'((i / 5) % 5);
        r.z = 3'(i % 5);
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] encode(input coord_t c);
    return 7'(c.x) * 7'd25 + 7'(c.y) * 7'd5 + 7'(c.z);
  endfunction

  function automatic logic [2:0] add5(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd5) s = s - 4'd5;
    return s[2:0];
  endfunction

  function automatic logic [2:0] neg5(input logic [2:0] a);
    return (a == 3'd0) ? 3'd0 : 3'd5 - a;
  endfunction

  // Product of two 3-bit values reduced mod 5
  function automatic logic [2:0] mul5(input logic [2:0] a, input logic [2:0] b);
    logic [5:0] p;
    logic [2:0] r;
    p = {3'b000, a} * {3'b000, b};
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (p == 6'(i)) r = 3'(i % 5);
    end
    return r;
  endfunction

  function automatic coord_t neg_c(input coord_t c);
    coord_t r;
    r.x = neg5(c.x);
    r.y = neg5(c.y);
    r.z = neg5(c.z);
    return r;
  endfunction

  // Move every member of a set by c: one 5-way selection per axis
  function automatic gset_t rot_group(input gset_t src, input coord_t c);
    gset_t t0;
    gset_t t1;
    gset_t t2;
    t0 = '0;
    t1 = '0;
    t2 = '0;
    for (int x = 0; x < AXIS; x++)
      for (int y = 0; y < AXIS; y++)
        for (int z = 0; z < AXIS; z++)
          for (int s = 0; s < AXIS; s++)
            if (c.z == 3'(s))
              t0[x*25 + y*5 + z] = src[x*25 + y*5 + (z + AXIS - s) % AXIS];
    for (int x = 0; x < AXIS; x++)
      for (int y = 0; y < AXIS; y++)
        for (int z = 0; z < AXIS; z++)
          for (int s = 0; s < AXIS; s++)
            if (c.y == 3'(s))
              t1[x*25 + y*5 + z] = t0[x*25 + ((y + AXIS - s) % AXIS)*5 + z];
    for (int x = 0; x < AXIS; x++)
      for (int y = 0; y < AXIS; y++)
        for (int z = 0; z < AXIS; z++)
          for (int s = 0; s < AXIS; s++)
            if (c.x == 3'(s))
              t2[x*25 + y*5 + z] = t1[((x + AXIS - s) % AXIS)*25 + y*5 + z];
    return t2;
  endfunction

endpackage

FILE: design/szsr_ctrl.sv
// ----------------------------------------------------------------------------
// szsr_ctrl
// Controller: sequences load, update steps, commit and result hand-off.
// ----------------------------------------------------------------------------
module szsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  szsr_pkg::szsr_stat_t stat,
  output szsr_pkg::szsr_cmd_t  cmd
);
  import szsr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   ok;
  logic   ok_next;

  assign s_tready = (state == S_IDLE);

  // Decode commands for the current state
  always_comb begin
    cmd        = '0;
    state_next = state;
    ok_next    = ok;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!stat.is_add) begin
          cmd.clear  = 1'b1;
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else if (stat.count_zero) begin
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else if (stat.step_fail) begin
          ok_next    = 1'b0;
          state_next = S_DONE;
        end else if (stat.count_one) begin
          cmd.commit = 1'b1;
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.out_ok = ok;
  end

  // Hold state, outcome flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ok       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ok    <= ok_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/szsr_dp.sv
// ----------------------------------------------------------------------------
// szsr_dp
// Datapath: reach layers, working copy, single-term update and running sum.
// ----------------------------------------------------------------------------
module szsr_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 command,
  input  logic [6:0]           element,
  input  logic [2:0]           multiplicity,
  input  szsr_pkg::szsr_cmd_t  cmd,
  output szsr_pkg::szsr_stat_t stat,
  output logic                 accepted,
  output logic [6:0]           completing_element
);
  import szsr_pkg::*;

  gset_t      layers    [MAX_TERMS];
  gset_t      work      [MAX_TERMS];
  gset_t      work_next [MAX_TERMS];
  coord_t     elem;
  coord_t     elem_neg;
  coord_t     run_sum;
  coord_t     run_sum_next;
  coord_t     scaled;
  logic [2:0] mult;
  logic [2:0] mult_mod;
  logic [2:0] count;
  logic       is_add;
  logic [6:0] neg_idx;
  logic       fail;

  // One appended copy: move each lower layer by the element and merge
  always_comb begin
    for (int l = 0; l < MAX_TERMS; l++) begin
      if (l == 0) begin
        work_next[l] = work[l] | rot_group(gset_t'(1), elem);
      end else begin
        work_next[l] = work[l] | rot_group(work[l-1], elem);
      end
    end
  end

  // Zero becomes reachable when the element is zero or its negation is already in a lower layer
  assign elem_neg = neg_c(elem);
  assign neg_idx  = encode(elem_neg);

  always_comb begin
    fail = (elem == coord_t'('0));
    for (int l = 0; l < MAX_TERMS - 1; l++) begin
      fail = fail | work[l][neg_idx];
    end
  end

  // Running sum advances by (multiplicity mod 5) times the element
  assign mult_mod       = mul5(mult, 3'd1);
  assign scaled.x       = mul5(mult_mod, elem.x);
  assign scaled.y       = mul5(mult_mod, elem.y);
  assign scaled.z       = mul5(mult_mod, elem.z);
  assign run_sum_next.x = add5(run_sum.x, scaled.x);
  assign run_sum_next.y = add5(run_sum.y, scaled.y);
  assign run_sum_next.z = add5(run_sum.z, scaled.z);

  assign stat.is_add     = is_add;
  assign stat.count_zero = (count == 3'd0);
  assign stat.count_one  = (count == 3'd1);
  assign stat.step_fail  = fail;

  // Capture the request and snapshot the layers; a step decrements the count and keeps the updated copy
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_add <= (command == CMD_ADD);
      elem   <= decode(element);
      mult   <= multiplicity;
      count  <= multiplicity;
      for (int l = 0; l < MAX_TERMS; l++) work[l] <= layers[l];
    end else if (cmd.step) begin
      count <= count - 3'd1;
      for (int l = 0; l < MAX_TERMS; l++) work[l] <= work_next[l];
    end
  end

  // Committed layers and running sum
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int l = 0; l < MAX_TERMS; l++) layers[l] <= '0;
      run_sum <= '0;
    end else if (cmd.commit) begin
      for (int l = 0; l < MAX_TERMS; l++) layers[l] <= work_next[l];
      run_sum <= run_sum_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted           <= cmd.out_ok;
      completing_element <= encode(neg_c(run_sum));
    end
  end

endmodule

FILE: design/short_zero_sum_reach_tracker_top.sv
// ----------------------------------------------------------------------------
// short_zero_sum_reach_tracker_top
// Zero-sum reach tracker over Z5^3 with stream request and result channels.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser selects clear (0) or add (1),
// s_tdata carries the element and the number of copies to append. Each
// request yields exactly one result on the m_ channel: an accepted flag and
// the element that would bring the running total back to zero.
// An add of m copies runs one single-term update per cycle; a request
// passes through load, m updates and result load, while a clear, a zero
// copy count, or an add rejected on its first update performs no update. A
// rejected add stops at the failing update. The update rate is set by the
// one shared layer-update unit in the datapath.
// s_tready is high only while the controller is idle; the result sits in an
// output register, so a new request is taken while the previous result waits.
// If the receiver stalls, the finished request waits until the output
// register frees before the next one is accepted.
// Reset empties every reach layer and zeroes the running sum.
// ----------------------------------------------------------------------------
module short_zero_sum_reach_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // element[6:0], multiplicity[9:7], zero pad
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // accepted[0], completing_element[7:1]
);
  import szsr_pkg::*;

  szsr_cmd_t  cmd;
  szsr_stat_t stat;
  logic       accepted;
  logic [6:0] completing_element;

  szsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  szsr_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .command            (s_tuser),
    .element            (s_tdata[6:0]),
    .multiplicity       (s_tdata[9:7]),
    .cmd                (cmd),
    .stat               (stat),
    .accepted           (accepted),
    .completing_element (completing_element)
  );

  assign m_tdata = {completing_element, accepted};

endmodule
